>>> rtl/core/psm_pkg.sv
// Shared types and constants for the process schedule metrics block.
// Holds the table entry layout, policy codes and register indexes.
// No dependencies.
package psm_pkg;

  localparam int MAX_PROCS_DEF = 64;

  localparam int ID_W    = 8;
  localparam int BURST_W = 16;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 22;
  localparam int SUM_W   = 28;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_RR   = 2'd2;
  localparam logic [1:0] POL_PRIO = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_SLICE  = 1'b1;

  localparam logic [BURST_W-1:0] SLICE_RESET = 16'd4;

endpackage

>>> rtl/core/psm_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module psm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/process_schedule_metrics_top.sv
// Process schedule metrics: loads a process table, schedules it, reports waits.
// After the last item, shortest job first and priority walk the table once per slot,
// round robin makes a copy pass and then passes until one finds no work, and first
// come first served goes straight to output. Results stream out one per cycle, and the
// receiver cannot stall them. Loading takes one item per cycle while idle, each one
// write to the entry memory. Reset is synchronous and clears control state only.
module process_schedule_metrics_top #(
  parameter int MAX_PROCS = psm_pkg::MAX_PROCS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [psm_pkg::ID_W-1:0]      proc_id,
  input  logic [psm_pkg::BURST_W-1:0]   burst,
  input  logic [psm_pkg::PRIO_W-1:0]    prio,
  input  logic                          last_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [psm_pkg::BURST_W-1:0]   cfg_data,
  output logic                          out_valid,
  output logic [psm_pkg::ID_W-1:0]      out_id,
  output logic [psm_pkg::BURST_W-1:0]   out_burst,
  output logic [psm_pkg::PRIO_W-1:0]    out_prio,
  output logic [psm_pkg::TIME_W-1:0]    wait_time,
  output logic [psm_pkg::TIME_W-1:0]    turnaround,
  output logic [psm_pkg::SUM_W-1:0]     sum_wait,
  output logic [psm_pkg::SUM_W-1:0]     sum_turnaround,
  output logic                          final_result
);
  import psm_pkg::*;

  localparam int AW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HEAD, S_CUR, S_SCAN, S_END, S_END2, S_RINIT, S_RPASS, S_OUT
  } state_t;

  state_t state;

  logic [1:0]         policy;
  logic [BURST_W-1:0] time_slice;

  logic [CW-1:0] cnt, n, i, k;
  logic          rv;
  logic [AW-1:0] rk, pos;
  entry_t        cur, orig;
  logic          pass_busy;
  logic [TIME_W-1:0] sim_clock, acc;
  logic [SUM_W-1:0]  sw, st;

  // Memory ports.
  logic               e_we, r_we, w_we;
  logic [AW-1:0]      e_wa, e_ra, r_ra;
  entry_t             e_wd;
  logic [ENTRY_W-1:0] e_q;
  logic [BURST_W-1:0] r_wd, r_q;
  logic [TIME_W-1:0]  w_wd, w_q;
  entry_t             qe;

  // Shared arithmetic.
  logic [BURST_W-1:0] quantum, step;
  logic               r_gt;
  logic [TIME_W-1:0]  nclk, rr_wait, ow, ot;
  logic [CW-1:0]      cnt_next, i_next;
  logic               cnt_room, issue, scan_done, swap_hit;

  psm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_q)
  );

  psm_ram #(.WIDTH(BURST_W), .DEPTH(MAX_PROCS)) u_remain_ram (
    .clk(clk), .we(r_we), .waddr(rk), .wdata(r_wd), .raddr(r_ra), .rdata(r_q)
  );

  psm_ram #(.WIDTH(TIME_W), .DEPTH(MAX_PROCS)) u_wait_ram (
    .clk(clk), .we(w_we), .waddr(rk), .wdata(w_wd), .raddr(r_ra), .rdata(w_q)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  always_comb begin
    qe        = entry_t'(e_q);
    quantum   = (time_slice == '0) ? BURST_W'(1) : time_slice;
    r_gt      = (r_q > quantum);
    step      = r_gt ? quantum : r_q;
    nclk      = sim_clock + TIME_W'(step);
    rr_wait   = nclk - TIME_W'(qe.burst);
    ow        = (policy == POL_RR) ? w_q : acc;
    ot        = ow + TIME_W'(qe.burst);
    cnt_room  = (cnt < CW'(MAX_PROCS));
    cnt_next  = cnt_room ? cnt + CW'(1) : cnt;
    i_next    = i + CW'(1);
    issue     = (k < n);
    scan_done = !issue && !rv;
    swap_hit  = (cur.prio > qe.prio);

    e_we = 1'b0;
    e_wa = rk;
    e_wd = cur;
    e_ra = k[AW-1:0];
    r_ra = k[AW-1:0];
    r_we = 1'b0;
    r_wd = '0;
    w_we = 1'b0;
    w_wd = '0;

    case (state)
      S_IDLE: begin
        e_we = start && cnt_room;
        e_wa = cnt[AW-1:0];
        e_wd = '{id: proc_id, burst: burst, prio: prio};
      end
      S_HEAD: begin
        e_ra = i[AW-1:0];
      end
      S_SCAN: begin
        // Priority order swaps the held entry into each later slot that ranks ahead.
        e_we = rv && (policy == POL_PRIO) && swap_hit;
      end
      S_END: begin
        e_we = 1'b1;
        e_wa = i[AW-1:0];
      end
      S_END2: begin
        e_we = 1'b1;
        e_wa = pos;
        e_wd = orig;
      end
      S_RINIT: begin
        r_we = rv;
        r_wd = qe.burst;
        w_we = rv;
      end
      S_RPASS: begin
        r_we = rv && (r_q != '0);
        r_wd = r_gt ? r_q - quantum : '0;
        w_we = rv && (r_q != '0) && !r_gt;
        w_wd = rr_wait;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      policy       <= POL_FCFS;
      time_slice   <= SLICE_RESET;
      cnt          <= '0;
      rv           <= 1'b0;
      out_valid    <= 1'b0;
      final_result <= 1'b0;
      sim_clock    <= '0;
    end else begin
      out_valid    <= 1'b0;
      final_result <= 1'b0;

      if (state == S_SCAN || state == S_RINIT || state == S_RPASS || state == S_OUT) begin
        if (issue) begin
          rv <= 1'b1;
          rk <= k[AW-1:0];
          k  <= k + CW'(1);
        end else begin
          rv <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == CFG_POLICY) begin
              policy <= cfg_data[1:0];
            end else begin
              time_slice <= cfg_data;
            end
          end
          if (start) begin
            cnt <= cnt_next;
            if (last_item) begin
              cnt <= '0;
              n   <= cnt_next;
              i   <= '0;
              k   <= '0;
              rv  <= 1'b0;
              acc <= '0;
              sw  <= '0;
              st  <= '0;
              case (policy)
                POL_SJF, POL_PRIO: state <= S_HEAD;
                POL_RR: begin
                  sim_clock <= '0;
                  state     <= S_RINIT;
                end
                default: state <= S_OUT;
              endcase
            end
          end
        end
        S_HEAD: begin
          state <= S_CUR;
        end
        S_CUR: begin
          cur   <= qe;
          orig  <= qe;
          pos   <= i[AW-1:0];
          k     <= i_next;
          rv    <= 1'b0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (rv) begin
            if (policy == POL_SJF) begin
              if (qe.burst < cur.burst) begin
                cur <= qe;
                pos <= rk;
              end
            end else if (swap_hit) begin
              cur <= qe;
            end
          end
          if (scan_done) begin
            state <= S_END;
          end
        end
        S_END, S_END2: begin
          if (state == S_END && policy == POL_SJF) begin
            state <= S_END2;
          end else if (i_next < n) begin
            i     <= i_next;
            state <= S_HEAD;
          end else begin
            k     <= '0;
            state <= S_OUT;
          end
        end
        S_RINIT: begin
          if (scan_done) begin
            k         <= '0;
            pass_busy <= 1'b0;
            state     <= S_RPASS;
          end
        end
        S_RPASS: begin
          if (rv && r_q != '0) begin
            pass_busy <= 1'b1;
            sim_clock <= nclk;
          end
          if (scan_done) begin
            k         <= '0;
            pass_busy <= 1'b0;
            if (!pass_busy) begin
              state <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (rv) begin
            out_valid  <= 1'b1;
            out_id     <= qe.id;
            out_burst  <= qe.burst;
            out_prio   <= qe.prio;
            wait_time  <= ow;
            turnaround <= ot;
            acc        <= acc + TIME_W'(qe.burst);
            sw         <= sw + SUM_W'(ow);
            st         <= st + SUM_W'(ot);
            if (CW'(rk) + CW'(1) == n) begin
              final_result   <= 1'b1;
              sum_wait       <= sw + SUM_W'(ow);
              sum_turnaround <= st + SUM_W'(ot);
            end else begin
              sum_wait       <= '0;
              sum_turnaround <= '0;
            end
          end
          if (scan_done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/psm_checker.sv
// Port-level checks for the process schedule metrics block, bound to the top level.
// Depends on psm_pkg for field widths.
module psm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          last_item,
  input logic                          out_valid,
  input logic [psm_pkg::BURST_W-1:0]   out_burst,
  input logic [psm_pkg::TIME_W-1:0]    wait_time,
  input logic [psm_pkg::TIME_W-1:0]    turnaround,
  input logic [psm_pkg::SUM_W-1:0]     sum_wait,
  input logic [psm_pkg::SUM_W-1:0]     sum_turnaround,
  input logic                          final_result
);
  import psm_pkg::*;

  // Results only stream out while a run is in progress.
  a_out_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> busy)
    else $error("result beat outside a run");

  a_final_valid: assert property (@(posedge clk) disable iff (rst) final_result |-> out_valid)
    else $error("final flag without a result beat");

  a_sums_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !final_result) |-> (sum_wait == '0 && sum_turnaround == '0))
    else $error("totals shown before the final beat");

  a_turn: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (turnaround == TIME_W'(wait_time + TIME_W'(out_burst))))
    else $error("turnaround differs from wait plus burst");

  a_run_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_item) |=> busy)
    else $error("last item did not start a run");

endmodule

bind process_schedule_metrics_top psm_checker u_psm_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .last_item(last_item),
  .out_valid(out_valid), .out_burst(out_burst), .wait_time(wait_time),
  .turnaround(turnaround), .sum_wait(sum_wait), .sum_turnaround(sum_turnaround),
  .final_result(final_result)
);

>>> dv/tb_process_schedule_metrics_top.sv
// Self-checking testbench for process_schedule_metrics_top: loads process tables,
// predicts every schedule result and compares the output stream field by field.
// Depends on psm_pkg and the process_schedule_metrics_top RTL.
module tb_process_schedule_metrics_top;
  import psm_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic               last;
  } proc_item_t;

  typedef struct {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [TIME_W-1:0]  waited;
    logic [TIME_W-1:0]  turn;
    logic [SUM_W-1:0]   wait_total;
    logic [SUM_W-1:0]   turn_total;
    logic               fin;
  } sched_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [ID_W-1:0] proc_id = '0;
  logic [BURST_W-1:0] burst = '0;
  logic [PRIO_W-1:0] prio = '0;
  logic last_item = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = CFG_POLICY;
  logic [BURST_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [ID_W-1:0] out_id;
  logic [BURST_W-1:0] out_burst;
  logic [PRIO_W-1:0] out_prio;
  logic [TIME_W-1:0] wait_time;
  logic [TIME_W-1:0] turnaround;
  logic [SUM_W-1:0] sum_wait;
  logic [SUM_W-1:0] sum_turnaround;
  logic final_result;

  process_schedule_metrics_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .proc_id(proc_id), .burst(burst), .prio(prio), .last_item(last_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_id(out_id),
    .out_burst(out_burst), .out_prio(out_prio), .wait_time(wait_time),
    .turnaround(turnaround), .sum_wait(sum_wait), .sum_turnaround(sum_turnaround),
    .final_result(final_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  proc_item_t pending_procs[$];
  sched_row_t expected_rows[$];

  // Shadow of the block's configuration and table.
  logic [1:0]         cur_policy = POL_FCFS;
  logic [BURST_W-1:0] cur_slice = SLICE_RESET;
  logic [ID_W-1:0]    tbl_id[TABLE_DEPTH];
  logic [BURST_W-1:0] tbl_burst[TABLE_DEPTH];
  logic [PRIO_W-1:0]  tbl_prio[TABLE_DEPTH];
  int                 tbl_count = 0;

  int  mismatches = 0;
  int  rows_seen = 0;
  int  tables_run = 0;
  int  beats_in = 0;
  int  cycles = 0;
  bit  steady = 0;

  task automatic swap_rows(int a, int b);
    logic [ID_W-1:0] t_id;
    logic [BURST_W-1:0] t_burst;
    logic [PRIO_W-1:0] t_prio;
    t_id = tbl_id[a]; tbl_id[a] = tbl_id[b]; tbl_id[b] = t_id;
    t_burst = tbl_burst[a]; tbl_burst[a] = tbl_burst[b]; tbl_burst[b] = t_burst;
    t_prio = tbl_prio[a]; tbl_prio[a] = tbl_prio[b]; tbl_prio[b] = t_prio;
  endtask

  // Schedules the held table under the current policy and queues its rows.
  task automatic schedule_table();
    logic [TIME_W-1:0] waits[TABLE_DEPTH];
    logic [BURST_W-1:0] left[TABLE_DEPTH];
    logic [TIME_W-1:0] clock_rr;
    logic [TIME_W-1:0] acc;
    logic [SUM_W-1:0] sw;
    logic [SUM_W-1:0] st;
    logic [BURST_W-1:0] quantum;
    sched_row_t row;
    int n;
    int pos;
    bit running;
    n = tbl_count;
    tbl_count = 0;
    if (cur_policy == POL_SJF) begin
      for (int i = 0; i < n; i++) begin
        pos = i;
        for (int k = i + 1; k < n; k++)
          if (tbl_burst[k] < tbl_burst[pos]) pos = k;
        swap_rows(i, pos);
      end
    end else if (cur_policy == POL_PRIO) begin
      for (int i = 0; i < n; i++)
        for (int k = i + 1; k < n; k++)
          if (tbl_prio[i] > tbl_prio[k]) swap_rows(i, k);
    end
    if (cur_policy == POL_RR) begin
      quantum = (cur_slice == 0) ? 16'd1 : cur_slice;
      clock_rr = '0;
      for (int i = 0; i < n; i++) begin
        left[i] = tbl_burst[i];
        waits[i] = '0;
      end
      running = 1;
      while (running) begin
        running = 0;
        for (int i = 0; i < n; i++) begin
          if (left[i] != 0) begin
            running = 1;
            if (left[i] > quantum) begin
              clock_rr += TIME_W'(quantum);
              left[i] -= quantum;
            end else begin
              clock_rr += TIME_W'(left[i]);
              waits[i] = clock_rr - TIME_W'(tbl_burst[i]);
              left[i] = '0;
            end
          end
        end
      end
    end else begin
      acc = '0;
      for (int i = 0; i < n; i++) begin
        waits[i] = acc;
        acc += TIME_W'(tbl_burst[i]);
      end
    end
    sw = '0;
    st = '0;
    for (int i = 0; i < n; i++) begin
      row.id = tbl_id[i];
      row.burst = tbl_burst[i];
      row.prio = tbl_prio[i];
      row.waited = waits[i];
      row.turn = waits[i] + TIME_W'(tbl_burst[i]);
      sw += SUM_W'(row.waited);
      st += SUM_W'(row.turn);
      row.fin = (i == n - 1);
      row.wait_total = row.fin ? sw : '0;
      row.turn_total = row.fin ? st : '0;
      expected_rows.push_back(row);
    end
    tables_run++;
  endtask

  // Driver: presents the oldest pending process and holds it until accepted.
  always @(posedge clk) begin
    proc_item_t nxt;
    bit taken;
    if (rst) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        beats_in++;
        if (tbl_count < TABLE_DEPTH) begin
          tbl_id[tbl_count] = proc_id;
          tbl_burst[tbl_count] = burst;
          tbl_prio[tbl_count] = prio;
          tbl_count++;
        end
        if (last_item) schedule_table();
        void'(pending_procs.pop_front());
      end
      if (!start || taken) begin
        if (pending_procs.size() > 0 && (steady || $urandom_range(99) >= 31)) begin
          nxt = pending_procs[0];
          proc_id <= nxt.id;
          burst <= nxt.burst;
          prio <= nxt.prio;
          last_item <= nxt.last;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result beat must match the oldest expected row.
  always @(posedge clk) begin
    sched_row_t exp_row;
    if (!rst && out_valid) begin
      rows_seen++;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: id %0d", out_id);
      end else begin
        exp_row = expected_rows.pop_front();
        if (out_id !== exp_row.id || out_burst !== exp_row.burst ||
            out_prio !== exp_row.prio || wait_time !== exp_row.waited ||
            turnaround !== exp_row.turn || sum_wait !== exp_row.wait_total ||
            sum_turnaround !== exp_row.turn_total || final_result !== exp_row.fin) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp id %0d burst %0d prio %0d wait %0d turn %0d",
                     exp_row.id, exp_row.burst, exp_row.prio, exp_row.waited,
                     exp_row.turn);
            $display("  exp sums %0d/%0d fin %0b", exp_row.wait_total,
                     exp_row.turn_total, exp_row.fin);
            $display("  got id %0d burst %0d prio %0d wait %0d turn %0d",
                     out_id, out_burst, out_prio, wait_time, turnaround);
            $display("  got sums %0d/%0d fin %0b", sum_wait, sum_turnaround,
                     final_result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("process_schedule_metrics_top verification failed");
      $finish;
    end
  end

  task automatic add_proc(int id, int b, int p, bit last);
    proc_item_t it;
    it.id = ID_W'(id);
    it.burst = BURST_W'(b);
    it.prio = PRIO_W'(p);
    it.last = last;
    pending_procs.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_procs.size() != 0 || start || expected_rows.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [BURST_W-1:0] data);
    repeat ($urandom_range(1, 3)) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_POLICY) cur_policy = data[1:0];
    else cur_slice = data;
  endtask

  task automatic set_mode(logic [1:0] pol, logic [BURST_W-1:0] slice);
    write_reg(CFG_POLICY, {14'd0, pol});
    write_reg(CFG_SLICE, slice);
  endtask

  // Random table; ties are made likely by drawing prio from a narrow range at times.
  task automatic add_table(int n, int burst_max);
    int b;
    int p;
    bit narrow;
    narrow = 1'($urandom_range(1));
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(7))
        0: b = 0;
        1: b = burst_max;
        default: b = $urandom_range(burst_max);
      endcase
      p = narrow ? $urandom_range(3) : $urandom_range(255);
      add_proc($urandom_range(255), b, p, i == n - 1);
    end
  endtask

  function automatic int rr_burst_cap(logic [1:0] pol, logic [BURST_W-1:0] slice);
    int cap;
    cap = (pol == POL_RR) ? ((slice == 0 ? 1 : slice) * 6) : 65535;
    return cap > 65535 ? 65535 : cap;
  endfunction

  initial begin
    logic [1:0] pol;
    logic [BURST_W-1:0] slice;
    int burst_cap;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Field extremes under first come first served, then a one-entry table.
    add_proc(0, 0, 0, 0);
    add_proc(255, 65535, 255, 1);
    add_proc(170, 85, 85, 1);
    wait_drained();
    // Shortest job first with tied bursts.
    set_mode(POL_SJF, 16'd4);
    add_proc(1, 9, 3, 0); add_proc(2, 5, 1, 0); add_proc(3, 5, 2, 0);
    add_proc(4, 0, 0, 1);
    wait_drained();
    // Priority with tied priorities.
    set_mode(POL_PRIO, 16'd4);
    add_proc(5, 7, 2, 0); add_proc(6, 3, 1, 0); add_proc(7, 4, 2, 0);
    add_proc(8, 6, 1, 1);
    wait_drained();
    // Round robin at the widest quantum, with a zero burst mixed in.
    set_mode(POL_RR, 16'hFFFF);
    add_proc(9, 65535, 4, 0); add_proc(10, 0, 5, 0); add_proc(11, 3, 6, 1);
    wait_drained();
    // A zero quantum behaves as a quantum of one.
    set_mode(POL_RR, 16'd0);
    add_proc(12, 5, 0, 0); add_proc(13, 0, 0, 0); add_proc(14, 2, 0, 0);
    add_proc(15, 3, 0, 1);
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      pol = (ph < 4) ? ph[1:0] : 2'($urandom_range(3));
      case ($urandom_range(4))
        0: slice = 16'd1;
        1: slice = 16'hFFFF;
        2: slice = 16'd0;
        default: slice = BURST_W'($urandom_range(1, 300));
      endcase
      set_mode(pol, slice);
      burst_cap = rr_burst_cap(pol, slice);
      steady = (ph == 5);
      if (ph == 5) add_table(64, burst_cap);
      // More items than the table holds: the overflow is dropped.
      else if (ph == 9) add_table(66, burst_cap);
      else repeat ($urandom_range(1, 3)) add_table($urandom_range(1, 6), burst_cap);
      wait_drained();
    end

    $display("%0d process beats loaded into %0d tables, %0d scheduled rows checked",
             beats_in, tables_run, rows_seen);
    $display("all four policies covered, including zero and full-width quanta");
    if (mismatches == 0) begin
      $display("process_schedule_metrics_top verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("process_schedule_metrics_top verification failed");
    end
    $finish;
  end

endmodule
